>>> rtl/hutv_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package hutv_pkg;

    // Queue between the classifier and the parser.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = 2;

    // Byte values the block looks for.
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_QUERY   = 8'h3F;
    localparam logic [7:0] CH_AT      = 8'h40;
    localparam logic [7:0] CH_HASH    = 8'h23;
    localparam logic [7:0] CH_LBRACK  = 8'h5B;
    localparam logic [7:0] CH_RBRACK  = 8'h5D;
    localparam logic [7:0] CH_COLON   = 8'h3A;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_DEL     = 8'h7F;
    localparam logic [7:0] CH_LOWER_H = 8'h68;
    localparam logic [7:0] CH_LOWER_T = 8'h74;
    localparam logic [7:0] CH_LOWER_P = 8'h70;
    localparam logic [7:0] CH_LOWER_S = 8'h73;

    // Scheme prefix positions and lengths.
    localparam logic [3:0] SCHEME_SEL_POS   = 4'd4;
    localparam logic [3:0] SCHEME_LEN_HTTP  = 4'd7;
    localparam logic [3:0] SCHEME_LEN_HTTPS = 4'd8;

    // Region tag carried with each result.
    typedef enum logic [1:0] {
        REGION_SCHEME = 2'd0,
        REGION_AUTH   = 2'd1,
        REGION_PATH   = 2'd2,
        REGION_REJECT = 2'd3
    } region_t;

    // Byte classes found by the front end.
    typedef struct packed {
        logic is_slash;
        logic is_query;
        logic is_at;
        logic is_hash;
        logic is_lbrack;
        logic is_rbrack;
        logic is_colon;
        logic is_digit;
        logic is_s;
        logic forbidden;
    } cls_t;

    // One classified byte travelling through the queue.
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        cls_t       cls;
    } item_t;

    // Expected byte of the scheme prefix at a position other than the selector.
    function automatic logic [7:0] scheme_char(input logic [3:0] pos, input logic https);
        logic [7:0] ch;
        ch = 8'h00;
        case (pos)
            4'd0: ch = CH_LOWER_H;
            4'd1: ch = CH_LOWER_T;
            4'd2: ch = CH_LOWER_T;
            4'd3: ch = CH_LOWER_P;
            4'd4: ch = https ? CH_LOWER_S : CH_COLON;
            4'd5: ch = https ? CH_COLON : CH_SLASH;
            4'd6: ch = CH_SLASH;
            4'd7: ch = CH_SLASH;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

`default_nettype wire

>>> rtl/hutv_front.sv
`timescale 1ns / 1ps
`default_nettype none

module hutv_front (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_tvalid,
    output logic                s_tready,
    input  wire logic [7:0]     s_tdata,
    input  wire logic           s_tlast,
    input  wire logic           q_full,
    output logic                q_push,
    output hutv_pkg::item_t     q_item
);

    logic            valid_reg;
    logic            valid_next;
    hutv_pkg::item_t item_reg;
    hutv_pkg::cls_t  cls;
    logic            take;

    // Classify the incoming byte.
    always_comb begin
        cls.is_slash  = (s_tdata == hutv_pkg::CH_SLASH);
        cls.is_query  = (s_tdata == hutv_pkg::CH_QUERY);
        cls.is_at     = (s_tdata == hutv_pkg::CH_AT);
        cls.is_hash   = (s_tdata == hutv_pkg::CH_HASH);
        cls.is_lbrack = (s_tdata == hutv_pkg::CH_LBRACK);
        cls.is_rbrack = (s_tdata == hutv_pkg::CH_RBRACK);
        cls.is_colon  = (s_tdata == hutv_pkg::CH_COLON);
        cls.is_digit  = (s_tdata >= hutv_pkg::CH_ZERO) && (s_tdata <= hutv_pkg::CH_NINE);
        cls.is_s      = (s_tdata == hutv_pkg::CH_LOWER_S);
        cls.forbidden = (s_tdata <= hutv_pkg::CH_SPACE) || (s_tdata == hutv_pkg::CH_DEL);
    end

    // The holding register drains into the queue whenever the queue has room.
    assign q_push   = valid_reg && !q_full;
    assign s_tready = !valid_reg || !q_full;
    assign take     = s_tvalid && s_tready;
    assign q_item   = item_reg;

    always_comb begin
        valid_next = valid_reg;
        if (take) begin
            valid_next = 1'b1;
        end else if (q_push) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Payload of the accepted transfer.
    always_ff @(posedge aclk) begin
        if (take) begin
            item_reg.data <= s_tdata;
            item_reg.last <= s_tlast;
            item_reg.cls  <= cls;
        end
    end

endmodule

`default_nettype wire

>>> rtl/hutv_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module hutv_queue (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            push,
    input  wire hutv_pkg::item_t push_item,
    output logic                 full,
    input  wire logic            pop,
    output logic                 avail,
    output hutv_pkg::item_t      head_item
);

    hutv_pkg::item_t                  slot_reg [hutv_pkg::QUEUE_DEPTH];
    logic [hutv_pkg::QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [hutv_pkg::QUEUE_PTR_W-1:0] wr_ptr_next;
    logic [hutv_pkg::QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [hutv_pkg::QUEUE_PTR_W-1:0] rd_ptr_next;
    logic [hutv_pkg::QUEUE_PTR_W:0]   count_reg;
    logic [hutv_pkg::QUEUE_PTR_W:0]   count_next;

    assign full      = (count_reg == (hutv_pkg::QUEUE_PTR_W + 1)'(hutv_pkg::QUEUE_DEPTH));
    assign avail     = (count_reg != '0);
    assign head_item = slot_reg[rd_ptr_reg];

    // Pointer and fill count update; the depth is a power of two so pointers wrap.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage slots.
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

>>> rtl/hutv_parser.sv
`timescale 1ns / 1ps
`default_nettype none

module hutv_parser #(
    parameter int MAX_AUTHORITY = 255,
    parameter int PATH_BUFFER   = 1024
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            q_avail,
    input  wire hutv_pkg::item_t q_item,
    output logic                 q_pop,
    output logic                 m_tvalid,
    input  wire logic            m_tready,
    output logic [31:0]          m_tdata,
    output logic [1:0]           m_tuser,
    output logic                 m_tlast
);

    localparam int AW = $clog2(MAX_AUTHORITY + 2);
    localparam int PW = $clog2(PATH_BUFFER + 1);

    // Parse state.
    logic [3:0]  sp_reg, sp_next;
    hutv_pkg::region_t rg_reg, rg_next;
    logic        https_reg, https_next;
    logic [AW-1:0] ac_reg, ac_next;
    logic [PW-1:0] pc_reg, pc_next;
    logic        br_reg, br_next;
    logic        in_reg, in_next;
    logic        cl_reg, cl_next;
    logic [1:0]  cc_reg, cc_next;
    logic        ne_reg, ne_next;
    logic        dg_reg, dg_next;
    logic        host_reg, host_next;
    logic        abc_reg, abc_next;
    logic        fpq_reg, fpq_next;
    logic        rej_reg, rej_next;

    // Output register.
    logic        ovalid_reg, ovalid_next;
    logic [7:0]  o_byte_reg;
    hutv_pkg::region_t o_region_reg;
    logic        o_last_reg;
    logic        o_acc_reg;
    logic        o_https_reg;
    logic [7:0]  o_alen_reg;
    logic [9:0]  o_plen_reg;
    logic        o_prep_reg;
    logic        o_port_reg;

    // Values computed for the byte at the head of the queue.
    hutv_pkg::region_t tag;
    logic        rej_fin;
    logic        path_go;
    logic        auth_ok;
    logic        tail;
    logic        step_ok;
    logic [PW-1:0] plen;
    logic        prep;
    logic [AW+7:0] ac_ext;
    logic [PW+9:0] plen_ext;
    logic [7:0]  alen_out;
    logic [9:0]  plen_out;
    logic [7:0]  c;
    hutv_pkg::cls_t cl;

    // Authority checks made when the authority ends.
    function automatic logic final_ok(
        input logic [AW-1:0] ac,
        input logic          br,
        input logic          cl_f,
        input logic [1:0]    cc,
        input logic          ne,
        input logic          dg,
        input logic          host
    );
        logic ok;
        ok = (ac != '0) && (ac <= AW'(MAX_AUTHORITY));
        if (br && !cl_f) begin
            ok = 1'b0;
        end
        if (cc != 2'd0) begin
            if (!ne || !dg || !host) begin
                ok = 1'b0;
            end
            if (!br && (cc != 2'd1)) begin
                ok = 1'b0;
            end
        end
        return ok;
    endfunction

    assign c     = q_item.data;
    assign cl    = q_item.cls;
    assign q_pop = q_avail && (!ovalid_reg || m_tready);

    // Next parse state for one byte.
    always_comb begin
        sp_next    = sp_reg;
        rg_next    = rg_reg;
        https_next = https_reg;
        ac_next    = ac_reg;
        pc_next    = pc_reg;
        br_next    = br_reg;
        in_next    = in_reg;
        cl_next    = cl_reg;
        cc_next    = cc_reg;
        ne_next    = ne_reg;
        dg_next    = dg_reg;
        host_next  = host_reg;
        abc_next   = abc_reg;
        fpq_next   = fpq_reg;
        rej_next   = rej_reg;
        tag        = rg_reg;
        path_go    = 1'b0;
        tail       = 1'b0;
        step_ok    = 1'b1;
        auth_ok    = final_ok(ac_reg, br_reg, cl_reg, cc_reg, ne_reg, dg_reg, host_reg);

        if (!rej_reg) begin
            case (rg_reg)
                hutv_pkg::REGION_SCHEME: begin
                    if (sp_reg == hutv_pkg::SCHEME_SEL_POS) begin
                        if (cl.is_s) begin
                            https_next = 1'b1;
                        end else if (!cl.is_colon) begin
                            rej_next = 1'b1;
                        end
                    end else begin
                        if ((sp_reg >= (https_reg ? hutv_pkg::SCHEME_LEN_HTTPS
                                                  : hutv_pkg::SCHEME_LEN_HTTP))
                            || (c != hutv_pkg::scheme_char(sp_reg, https_reg))) begin
                            rej_next = 1'b1;
                        end
                    end
                    if (!rej_next) begin
                        sp_next = sp_reg + 4'd1;
                        if (sp_next == (https_next ? hutv_pkg::SCHEME_LEN_HTTPS
                                                   : hutv_pkg::SCHEME_LEN_HTTP)) begin
                            rg_next = hutv_pkg::REGION_AUTH;
                        end
                    end
                end
                hutv_pkg::REGION_AUTH: begin
                    if ((cl.is_slash || cl.is_query) && !in_reg) begin
                        // End of the authority: check it, then treat the byte as path.
                        tag     = hutv_pkg::REGION_PATH;
                        rg_next = hutv_pkg::REGION_PATH;
                        if (!auth_ok) begin
                            rej_next = 1'b1;
                        end else begin
                            path_go = 1'b1;
                        end
                    end else if (cl.is_at || cl.is_hash || cl.forbidden) begin
                        rej_next = 1'b1;
                    end else begin
                        // Bracket tracking for a leading IPv6 literal.
                        if (cl.is_lbrack) begin
                            if (ac_reg == '0) begin
                                br_next = 1'b1;
                                in_next = 1'b1;
                            end else begin
                                rej_next = 1'b1;
                                step_ok  = 1'b0;
                            end
                        end else if (!br_reg) begin
                            if (cl.is_rbrack) begin
                                rej_next = 1'b1;
                                step_ok  = 1'b0;
                            end else begin
                                tail = 1'b1;
                            end
                        end else if (!cl_reg) begin
                            if (cl.is_rbrack) begin
                                if (ac_reg == AW'(1)) begin
                                    rej_next = 1'b1;
                                    step_ok  = 1'b0;
                                end else begin
                                    cl_next = 1'b1;
                                    in_next = 1'b0;
                                end
                            end
                        end else begin
                            tail = 1'b1;
                        end
                        // Host tail: colons and port digits.
                        if (step_ok && tail) begin
                            if (br_reg && !abc_reg) begin
                                abc_next = 1'b1;
                                if (!cl.is_colon) begin
                                    rej_next = 1'b1;
                                    step_ok  = 1'b0;
                                end
                            end
                            if (step_ok) begin
                                if (cl.is_colon) begin
                                    cc_next   = (cc_reg == 2'd3) ? 2'd3 : cc_reg + 2'd1;
                                    ne_next   = 1'b0;
                                    dg_next   = 1'b1;
                                    host_next = (ac_reg != '0);
                                end else if (cc_reg != 2'd0) begin
                                    ne_next = 1'b1;
                                    if (!cl.is_digit) begin
                                        dg_next = 1'b0;
                                    end
                                end
                            end
                        end
                        // Authority length.
                        if (step_ok) begin
                            if (ac_reg <= AW'(MAX_AUTHORITY)) begin
                                ac_next = ac_reg + 1'b1;
                            end
                            if (ac_next > AW'(MAX_AUTHORITY)) begin
                                rej_next = 1'b1;
                            end
                        end
                    end
                end
                hutv_pkg::REGION_PATH: begin
                    path_go = 1'b1;
                end
                default: begin
                end
            endcase
        end

        // Path or query byte.
        if (path_go) begin
            if (cl.is_hash || cl.forbidden) begin
                rej_next = 1'b1;
            end else begin
                if (pc_reg == '0) begin
                    fpq_next = cl.is_query;
                    pc_next  = cl.is_query ? PW'(2) : PW'(1);
                end else if (pc_reg < PW'(PATH_BUFFER)) begin
                    pc_next = pc_reg + 1'b1;
                end
                if (pc_next > PW'(PATH_BUFFER - 1)) begin
                    rej_next = 1'b1;
                end
            end
        end

        // Verdict on the last byte.
        rej_fin = rej_next;
        plen    = pc_next;
        prep    = fpq_next;
        if (q_item.last) begin
            if (!rej_next) begin
                if (rg_next == hutv_pkg::REGION_SCHEME) begin
                    rej_fin = 1'b1;
                end else if ((rg_next == hutv_pkg::REGION_AUTH)
                             && !final_ok(ac_next, br_next, cl_next, cc_next,
                                          ne_next, dg_next, host_next)) begin
                    rej_fin = 1'b1;
                end
            end
            if (pc_next == '0) begin
                plen = PW'(1);
                prep = 1'b1;
            end
        end
    end

    // Saturated lengths for the result.
    always_comb begin
        ac_ext   = {8'd0, ac_next};
        plen_ext = {10'd0, plen};
        alen_out = (ac_ext > (AW + 8)'(255)) ? 8'hFF : ac_ext[7:0];
        plen_out = (plen_ext > (PW + 10)'(1023)) ? 10'h3FF : plen_ext[9:0];
    end

    always_comb begin
        ovalid_next = ovalid_reg;
        if (q_pop) begin
            ovalid_next = 1'b1;
        end else if (m_tready) begin
            ovalid_next = 1'b0;
        end
    end

    // Control state; a last byte returns everything to the start of a target.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ovalid_reg <= 1'b0;
            sp_reg     <= '0;
            rg_reg     <= hutv_pkg::REGION_SCHEME;
            https_reg  <= 1'b0;
            ac_reg     <= '0;
            pc_reg     <= '0;
            br_reg     <= 1'b0;
            in_reg     <= 1'b0;
            cl_reg     <= 1'b0;
            cc_reg     <= '0;
            ne_reg     <= 1'b0;
            dg_reg     <= 1'b0;
            host_reg   <= 1'b0;
            abc_reg    <= 1'b0;
            fpq_reg    <= 1'b0;
            rej_reg    <= 1'b0;
        end else begin
            ovalid_reg <= ovalid_next;
            if (q_pop) begin
                if (q_item.last) begin
                    sp_reg    <= '0;
                    rg_reg    <= hutv_pkg::REGION_SCHEME;
                    https_reg <= 1'b0;
                    ac_reg    <= '0;
                    pc_reg    <= '0;
                    br_reg    <= 1'b0;
                    in_reg    <= 1'b0;
                    cl_reg    <= 1'b0;
                    cc_reg    <= '0;
                    ne_reg    <= 1'b0;
                    dg_reg    <= 1'b0;
                    host_reg  <= 1'b0;
                    abc_reg   <= 1'b0;
                    fpq_reg   <= 1'b0;
                    rej_reg   <= 1'b0;
                end else begin
                    sp_reg    <= sp_next;
                    rg_reg    <= rg_next;
                    https_reg <= https_next;
                    ac_reg    <= ac_next;
                    pc_reg    <= pc_next;
                    br_reg    <= br_next;
                    in_reg    <= in_next;
                    cl_reg    <= cl_next;
                    cc_reg    <= cc_next;
                    ne_reg    <= ne_next;
                    dg_reg    <= dg_next;
                    host_reg  <= host_next;
                    abc_reg   <= abc_next;
                    fpq_reg   <= fpq_next;
                    rej_reg   <= rej_next;
                end
            end
        end
    end

    // Result payload.
    always_ff @(posedge aclk) begin
        if (q_pop) begin
            o_byte_reg   <= c;
            o_region_reg <= rej_fin ? hutv_pkg::REGION_REJECT : tag;
            o_last_reg   <= q_item.last;
            o_acc_reg    <= q_item.last && !rej_fin;
            o_https_reg  <= https_next;
            o_alen_reg   <= alen_out;
            o_plen_reg   <= plen_out;
            o_prep_reg   <= prep;
            o_port_reg   <= (cc_next != 2'd0);
        end
    end

    assign m_tvalid = ovalid_reg;
    assign m_tuser  = o_region_reg;
    assign m_tlast  = o_last_reg;
    assign m_tdata  = {2'b00, o_port_reg, o_prep_reg, o_plen_reg, o_alen_reg,
                       o_https_reg, o_acc_reg, o_byte_reg};

endmodule

`default_nettype wire

>>> rtl/http_target_url_validator.sv
`timescale 1ns / 1ps
`default_nettype none

// A result passes through the classifier register, a queue slot and the parser output
// register before it is valid at the output.
// Throughput: one byte per cycle unless a stalled output fills the queue; the parser updates its state once per byte.
// A 4-entry queue lets the classifier keep taking bytes while the output stalls.
// Reset: aresetn is synchronous and active low; it empties the queue and returns
// the parser to the start of a new target.

module http_target_url_validator #(
    parameter int MAX_AUTHORITY = 255,
    parameter int PATH_BUFFER   = 1024
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // [7:0] echo_byte, [8] accepted, [9] is_https,
                                        // [17:10] authority_length, [27:18] path_length,
                                        // [28] prepend_slash, [29] has_port, [31:30] zero
    output logic [1:0]       m_tuser,   // [1:0] region
    output logic             m_tlast
);

    logic            q_full;
    logic            q_push;
    logic            q_pop;
    logic            q_avail;
    hutv_pkg::item_t push_item;
    hutv_pkg::item_t head_item;

    // Byte classifier.
    hutv_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_item   (push_item)
    );

    // Queue between classifier and parser.
    hutv_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .avail     (q_avail),
        .head_item (head_item)
    );

    // Parser and result register.
    hutv_parser #(
        .MAX_AUTHORITY (MAX_AUTHORITY),
        .PATH_BUFFER   (PATH_BUFFER)
    ) u_parser (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_avail  (q_avail),
        .q_item   (head_item),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire
